[design/dtl_pkg.sv]
package dtl_pkg;

   localparam int NUM_SLOTS_DEF  = 16;
   localparam int DELTA_BITS_DEF = 32;
   localparam int SLOT_BITS      = 8;
   localparam int TICK_BITS      = 32;

   localparam logic [SLOT_BITS-1:0] NONE_SLOT = '1;

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_CLEAR  = 2'd2,
      FUNC_READ   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_LINKED   = 2'd1,
      ST_UNLINKED = 2'd2
   } code_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_RD_SLOT,
      DP_RD_HEAD,
      DP_WALK,
      DP_LATCH,
      DP_RM_LINK,
      DP_RM_SELF,
      DP_INS_EMPTY,
      DP_LINK1,
      DP_LINK2,
      DP_APP1,
      DP_APP2,
      DP_CLEAR
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      cap;
      logic      load_rsp;
   } dtl_cmd_type;

   typedef struct packed {
      func_type func;
      logic     slot_ok;
      logic     refused;
      logic     empty;
      logic     hit;
      logic     walk_end;
   } dtl_stat_type;

endpackage

[design/dtl_req_if.sv]
interface dtl_req_if import dtl_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            func;
   logic [SLOT_BITS-1:0]  timer_slot;
   logic [TICK_BITS-1:0]  start_ticks;
   logic                  expired;

   modport source (output valid, func, timer_slot, start_ticks, expired, input ready);
   modport sink (input valid, func, timer_slot, start_ticks, expired, output ready);
endinterface

[design/dtl_rsp_if.sv]
interface dtl_rsp_if import dtl_pkg::*; #(parameter int DELTA_BITS = DELTA_BITS_DEF) ();
   logic                  valid;
   logic                  ready;
   logic [SLOT_BITS-1:0]  head_slot;
   logic [SLOT_BITS-1:0]  tail_slot;
   logic                  list_empty;
   logic [SLOT_BITS-1:0]  slot_next;
   logic [SLOT_BITS-1:0]  slot_prev;
   logic [DELTA_BITS-1:0] slot_delta;
   logic [1:0]            status;

   modport source (output valid, head_slot, tail_slot, list_empty, slot_next, slot_prev,
                   slot_delta, status, input ready);
   modport sink (input valid, head_slot, tail_slot, list_empty, slot_next, slot_prev,
                 slot_delta, status, output ready);
endinterface

[design/dtl_ram.sv]
module dtl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

[design/dtl_datapath.sv]
module dtl_datapath import dtl_pkg::*; #(
   parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
   parameter int DELTA_BITS = DELTA_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dtl_cmd_type           cmd,
   output dtl_stat_type          stat,
   input  logic [1:0]            req_func,
   input  logic [SLOT_BITS-1:0]  req_timer_slot,
   input  logic [TICK_BITS-1:0]  req_start_ticks,
   input  logic                  req_expired,
   output logic [SLOT_BITS-1:0]  rsp_head_slot,
   output logic [SLOT_BITS-1:0]  rsp_tail_slot,
   output logic                  rsp_list_empty,
   output logic [SLOT_BITS-1:0]  rsp_slot_next,
   output logic [SLOT_BITS-1:0]  rsp_slot_prev,
   output logic [DELTA_BITS-1:0] rsp_slot_delta,
   output logic [1:0]            rsp_status
);
   localparam int AW = $clog2(NUM_SLOTS);
   localparam int SW = $clog2(NUM_SLOTS + 1);
   localparam logic [DELTA_BITS-1:0] DELTA_MASK = '1;
   localparam logic [DELTA_BITS-1:0] DELTA_MAX  = DELTA_MASK - 1'b1;
   localparam logic [TICK_BITS-1:0]  TICK_MAX   = TICK_BITS'(DELTA_MAX);
   localparam logic [SLOT_BITS:0]    NUM_W      = (SLOT_BITS + 1)'(NUM_SLOTS);
   localparam logic [SW-1:0]         LAST_STEP  = SW'(NUM_SLOTS - 1);

   function automatic logic slot_ok(input logic [SLOT_BITS-1:0] s);
      return {1'b0, s} < NUM_W;
   endfunction

   func_type              func_ff;
   logic [SLOT_BITS-1:0]  slot_ff, t_ff, p_ff, n_ff, first_ff, last_ff;
   logic [SLOT_BITS-1:0]  first_in, last_in;
   logic [DELTA_BITS-1:0] rem_ff, ds_ff, dt_ff;
   logic                  exp_ff;
   code_type              code_ff, code_in;
   logic [SW-1:0]         steps_ff;
   logic [NUM_SLOTS-1:0]  in_list_ff, nvld_ff, pvld_ff, dvld_ff;
   logic                  nrv_ff, prv_ff, drv_ff;

   logic [SLOT_BITS-1:0]  rsp_head_ff, rsp_tail_ff, rsp_next_ff, rsp_prev_ff;
   logic                  rsp_empty_ff;
   logic [DELTA_BITS-1:0] rsp_delta_ff;
   code_type              rsp_code_ff;

   logic                  n_we, p_we, d_we, re;
   logic [SLOT_BITS-1:0]  n_wa, p_wa, d_wa, n_wd, p_wd, rsel;
   logic [DELTA_BITS-1:0] d_wd, rem_sat;
   logic [SLOT_BITS-1:0]  n_rd, p_rd, nq, pq;
   logic [DELTA_BITS-1:0] d_rd, dq;
   logic [DELTA_BITS:0]   sum;
   logic                  req_ok;

   dtl_ram #(.WIDTH(SLOT_BITS), .DEPTH(NUM_SLOTS)) u_next_ram (
      .clock(clock), .we(n_we), .waddr(n_wa[AW-1:0]), .wdata(n_wd),
      .re(re), .raddr(rsel[AW-1:0]), .rdata(n_rd));

   dtl_ram #(.WIDTH(SLOT_BITS), .DEPTH(NUM_SLOTS)) u_prev_ram (
      .clock(clock), .we(p_we), .waddr(p_wa[AW-1:0]), .wdata(p_wd),
      .re(re), .raddr(rsel[AW-1:0]), .rdata(p_rd));

   dtl_ram #(.WIDTH(DELTA_BITS), .DEPTH(NUM_SLOTS)) u_delta_ram (
      .clock(clock), .we(d_we), .waddr(d_wa[AW-1:0]), .wdata(d_wd),
      .re(re), .raddr(rsel[AW-1:0]), .rdata(d_rd));

   // entries never written read as their reset value
   assign nq = nrv_ff ? n_rd : NONE_SLOT;
   assign pq = prv_ff ? p_rd : NONE_SLOT;
   assign dq = drv_ff ? d_rd : DELTA_MASK;

   assign rem_sat = (req_start_ticks > TICK_MAX) ? DELTA_MAX : req_start_ticks[DELTA_BITS-1:0];
   assign req_ok  = slot_ok(req_timer_slot);
   assign sum     = {1'b0, dq} + {1'b0, ds_ff};

   always_comb begin
      code_in = ST_OK;
      if (req_ok && func_type'(req_func) == FUNC_INSERT
          && in_list_ff[req_timer_slot[AW-1:0]]) begin
         code_in = ST_LINKED;
      end else if (req_ok && func_type'(req_func) == FUNC_REMOVE
                   && !in_list_ff[req_timer_slot[AW-1:0]]) begin
         code_in = ST_UNLINKED;
      end
   end

   always_comb begin
      stat.func     = func_ff;
      stat.slot_ok  = slot_ok(slot_ff);
      stat.refused  = (code_ff != ST_OK);
      stat.empty    = (first_ff == NONE_SLOT);
      stat.hit      = (rem_ff <= dq);
      stat.walk_end = !slot_ok(nq) || (steps_ff == LAST_STEP);
   end

   always_comb begin
      re   = 1'b0;
      rsel = slot_ff;
      case (cmd.op)
         DP_RD_SLOT: begin
            re = 1'b1;
         end
         DP_RD_HEAD: begin
            re   = 1'b1;
            rsel = first_ff;
         end
         DP_WALK, DP_LATCH: begin
            re   = 1'b1;
            rsel = nq;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      n_we     = 1'b0;
      n_wa     = slot_ff;
      n_wd     = NONE_SLOT;
      p_we     = 1'b0;
      p_wa     = slot_ff;
      p_wd     = NONE_SLOT;
      d_we     = 1'b0;
      d_wa     = slot_ff;
      d_wd     = rem_ff;
      first_in = first_ff;
      last_in  = last_ff;
      case (cmd.op)
         DP_INS_EMPTY: begin
            n_we     = 1'b1;
            p_we     = 1'b1;
            d_we     = 1'b1;
            first_in = slot_ff;
            last_in  = slot_ff;
         end
         DP_LINK1: begin
            n_we = 1'b1;
            n_wd = t_ff;
            p_we = 1'b1;
            p_wd = p_ff;
            d_we = 1'b1;
         end
         DP_LINK2: begin
            p_we = 1'b1;
            p_wa = t_ff;
            p_wd = slot_ff;
            d_we = 1'b1;
            d_wa = t_ff;
            d_wd = dt_ff - rem_ff;
            if (slot_ok(p_ff)) begin
               n_we = 1'b1;
               n_wa = p_ff;
               n_wd = slot_ff;
            end else begin
               first_in = slot_ff;
            end
         end
         DP_APP1: begin
            n_we = 1'b1;
            p_we = 1'b1;
            p_wd = last_ff;
            d_we = 1'b1;
         end
         DP_APP2: begin
            if (slot_ok(last_ff)) begin
               n_we = 1'b1;
               n_wa = last_ff;
               n_wd = slot_ff;
            end
            last_in = slot_ff;
         end
         DP_RM_LINK: begin
            if (slot_ok(p_ff)) begin
               n_we = 1'b1;
               n_wa = p_ff;
               n_wd = n_ff;
            end else begin
               first_in = n_ff;
            end
            if (slot_ok(n_ff)) begin
               p_we = 1'b1;
               p_wa = n_ff;
               p_wd = p_ff;
            end else begin
               last_in = p_ff;
            end
            if (!exp_ff && slot_ok(n_ff)) begin
               d_we = 1'b1;
               d_wa = n_ff;
               d_wd = (sum > {1'b0, DELTA_MAX}) ? DELTA_MAX : sum[DELTA_BITS-1:0];
            end
         end
         DP_RM_SELF: begin
            n_we = 1'b1;
            p_we = 1'b1;
            d_we = 1'b1;
            d_wd = DELTA_MASK;
         end
         DP_CLEAR: begin
            first_in = NONE_SLOT;
            last_in  = NONE_SLOT;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff   <= NONE_SLOT;
         last_ff    <= NONE_SLOT;
         in_list_ff <= '0;
         nvld_ff    <= '0;
         pvld_ff    <= '0;
         dvld_ff    <= '0;
         nrv_ff     <= 1'b0;
         prv_ff     <= 1'b0;
         drv_ff     <= 1'b0;
      end else begin
         first_ff <= first_in;
         last_ff  <= last_in;
         if (re) begin
            nrv_ff <= slot_ok(rsel) && nvld_ff[rsel[AW-1:0]];
            prv_ff <= slot_ok(rsel) && pvld_ff[rsel[AW-1:0]];
            drv_ff <= slot_ok(rsel) && dvld_ff[rsel[AW-1:0]];
         end
         if (cmd.op == DP_CLEAR) begin
            nvld_ff    <= nvld_ff & ~in_list_ff;
            in_list_ff <= '0;
         end else begin
            if (n_we) nvld_ff[n_wa[AW-1:0]] <= 1'b1;
            if (p_we) pvld_ff[p_wa[AW-1:0]] <= 1'b1;
            if (d_we) dvld_ff[d_wa[AW-1:0]] <= 1'b1;
            if (cmd.op == DP_INS_EMPTY || cmd.op == DP_LINK1 || cmd.op == DP_APP1) begin
               in_list_ff[slot_ff[AW-1:0]] <= 1'b1;
            end else if (cmd.op == DP_RM_SELF) begin
               in_list_ff[slot_ff[AW-1:0]] <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         func_ff <= func_type'(req_func);
         slot_ff <= req_timer_slot;
         rem_ff  <= rem_sat;
         exp_ff  <= req_expired;
         code_ff <= code_in;
      end
      case (cmd.op)
         DP_RD_HEAD: begin
            t_ff     <= first_ff;
            steps_ff <= '0;
         end
         DP_WALK: begin
            if (rem_ff <= dq) begin
               p_ff  <= pq;
               dt_ff <= dq;
            end else begin
               rem_ff   <= rem_ff - dq;
               t_ff     <= nq;
               steps_ff <= steps_ff + 1'b1;
            end
         end
         DP_LATCH: begin
            n_ff  <= nq;
            p_ff  <= pq;
            ds_ff <= dq;
         end
         default: begin
         end
      endcase
      if (cmd.load_rsp) begin
         rsp_head_ff  <= first_ff;
         rsp_tail_ff  <= last_ff;
         rsp_empty_ff <= (first_ff == NONE_SLOT);
         rsp_code_ff  <= code_ff;
         if (func_ff != FUNC_READ) begin
            rsp_next_ff  <= '0;
            rsp_prev_ff  <= '0;
            rsp_delta_ff <= '0;
         end else if (slot_ok(slot_ff)) begin
            rsp_next_ff  <= nq;
            rsp_prev_ff  <= pq;
            rsp_delta_ff <= dq;
         end else begin
            rsp_next_ff  <= NONE_SLOT;
            rsp_prev_ff  <= NONE_SLOT;
            rsp_delta_ff <= DELTA_MASK;
         end
      end
   end

   assign rsp_head_slot  = rsp_head_ff;
   assign rsp_tail_slot  = rsp_tail_ff;
   assign rsp_list_empty = rsp_empty_ff;
   assign rsp_slot_next  = rsp_next_ff;
   assign rsp_slot_prev  = rsp_prev_ff;
   assign rsp_slot_delta = rsp_delta_ff;
   assign rsp_status     = rsp_code_ff;
endmodule

[design/dtl_ctrl.sv]
module dtl_ctrl import dtl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  dtl_stat_type stat,
   output dtl_cmd_type  cmd
);
   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_RD, S_LATCH, S_RM_LINK, S_RM_SELF, S_INS_EMPTY,
      S_HEAD, S_WALK, S_LINK1, S_LINK2, S_APP1, S_APP2, S_CLEAR, S_RSP
   } state_type;

   state_type state_ff;
   logic      req_ready_ff, rsp_valid_ff, rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd.cap      = (state_ff == S_IDLE) && req_valid && req_ready_ff;
      cmd.load_rsp = (state_ff == S_RSP) && rsp_free;
      case (state_ff)
         S_RD:        cmd.op = DP_RD_SLOT;
         S_LATCH:     cmd.op = DP_LATCH;
         S_RM_LINK:   cmd.op = DP_RM_LINK;
         S_RM_SELF:   cmd.op = DP_RM_SELF;
         S_INS_EMPTY: cmd.op = DP_INS_EMPTY;
         S_HEAD:      cmd.op = DP_RD_HEAD;
         S_WALK:      cmd.op = DP_WALK;
         S_LINK1:     cmd.op = DP_LINK1;
         S_LINK2:     cmd.op = DP_LINK2;
         S_APP1:      cmd.op = DP_APP1;
         S_APP2:      cmd.op = DP_APP2;
         S_CLEAR:     cmd.op = DP_CLEAR;
         default:     cmd.op = DP_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready_ff) begin
                  req_ready_ff <= 1'b0;
                  state_ff     <= S_DECODE;
               end
            end
            S_DECODE: begin
               case (stat.func)
                  FUNC_INSERT: begin
                     if (!stat.slot_ok || stat.refused) state_ff <= S_RSP;
                     else if (stat.empty)               state_ff <= S_INS_EMPTY;
                     else                               state_ff <= S_HEAD;
                  end
                  FUNC_REMOVE: begin
                     if (!stat.slot_ok || stat.refused) state_ff <= S_RSP;
                     else                               state_ff <= S_RD;
                  end
                  FUNC_CLEAR: state_ff <= S_CLEAR;
                  default:    state_ff <= S_RD;
               endcase
            end
            S_RD:        state_ff <= (stat.func == FUNC_READ) ? S_RSP : S_LATCH;
            S_LATCH:     state_ff <= S_RM_LINK;
            S_RM_LINK:   state_ff <= S_RM_SELF;
            S_RM_SELF:   state_ff <= S_RSP;
            S_INS_EMPTY: state_ff <= S_RSP;
            S_HEAD:      state_ff <= S_WALK;
            S_WALK: begin
               if (stat.hit)           state_ff <= S_LINK1;
               else if (stat.walk_end) state_ff <= S_APP1;
            end
            S_LINK1:     state_ff <= S_LINK2;
            S_LINK2:     state_ff <= S_RSP;
            S_APP1:      state_ff <= S_APP2;
            S_APP2:      state_ff <= S_RSP;
            S_CLEAR:     state_ff <= S_RSP;
            S_RSP: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  req_ready_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default:     state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;
endmodule

[design/delta_timer_list_unit.sv]
// Timer queue kept as a doubly linked delta list over NUM_SLOTS slots; each
// linked slot holds its ticks beyond its predecessor. One request is worked
// at a time. Refused or out-of-range insert and remove go straight to the
// result. Remove reads the slot, latches its links, relinks its neighbours
// and frees the slot. Insert into a non-empty list walks the list from the
// head through the next/delta memories, one entry per cycle, visiting at
// most NUM_SLOTS entries, then links the slot in or appends it at the tail.
// The result is loaded into an output register only once the previous one
// has been taken, so a stalled result adds its stall. req_ready rises with
// rsp_valid, so the next request can transfer in the cycle the result
// appears. Memories need no clearing pass: per-entry valid bits return
// reset values.
module delta_timer_list_unit import dtl_pkg::*; #(
   parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
   parameter int DELTA_BITS = DELTA_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   dtl_req_if.sink   req_chan,
   dtl_rsp_if.source rsp_chan
);
   dtl_cmd_type  cmd;
   dtl_stat_type stat;

   dtl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_chan.valid),
      .req_ready(req_chan.ready),
      .rsp_valid(rsp_chan.valid),
      .rsp_ready(rsp_chan.ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   dtl_datapath #(.NUM_SLOTS(NUM_SLOTS), .DELTA_BITS(DELTA_BITS)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_func       (req_chan.func),
      .req_timer_slot (req_chan.timer_slot),
      .req_start_ticks(req_chan.start_ticks),
      .req_expired    (req_chan.expired),
      .rsp_head_slot  (rsp_chan.head_slot),
      .rsp_tail_slot  (rsp_chan.tail_slot),
      .rsp_list_empty (rsp_chan.list_empty),
      .rsp_slot_next  (rsp_chan.slot_next),
      .rsp_slot_prev  (rsp_chan.slot_prev),
      .rsp_slot_delta (rsp_chan.slot_delta),
      .rsp_status     (rsp_chan.status)
   );
endmodule

[design/dtl_checker.sv]
module dtl_checker import dtl_pkg::*; #(
   parameter int DELTA_BITS = DELTA_BITS_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [SLOT_BITS-1:0]  head_slot,
   input logic [SLOT_BITS-1:0]  tail_slot,
   input logic                  list_empty,
   input logic [DELTA_BITS-1:0] slot_delta
);
   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (list_empty == (head_slot == NONE_SLOT)))
      else $error("list_empty disagrees with head_slot");

   a_empty_tail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && list_empty) |-> (tail_slot == NONE_SLOT))
      else $error("empty list reports a tail");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while one is in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(slot_delta)))
      else $error("stalled result changed");
endmodule

bind delta_timer_list_unit dtl_checker #(.DELTA_BITS(DELTA_BITS)) u_dtl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .head_slot (rsp_chan.head_slot),
   .tail_slot (rsp_chan.tail_slot),
   .list_empty(rsp_chan.list_empty),
   .slot_delta(rsp_chan.slot_delta)
);

[dv/tb.sv]
module tb;
   import dtl_pkg::*;

   localparam int NSLOT = NUM_SLOTS_DEF;
   localparam logic [31:0] DMASK = 32'hFFFF_FFFF;
   localparam logic [31:0] DMAX = 32'hFFFF_FFFE;
   localparam int WD_LIMIT = 20000;

   typedef struct packed {
      func_type    func;
      logic [7:0]  slot;
      logic [31:0] ticks;
      logic        expired;
   } timer_op_type;

   typedef struct packed {
      logic [7:0]  head;
      logic [7:0]  tail;
      logic        empty;
      logic [7:0]  nxt;
      logic [7:0]  prv;
      logic [31:0] delta;
      code_type    status;
   } list_view_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dtl_req_if req_chan ();
   dtl_rsp_if rsp_chan ();

   delta_timer_list_unit dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   always #5 clock = ~clock;

   logic [7:0]  m_next [NSLOT] = '{default: NONE_SLOT};
   logic [7:0]  m_prev [NSLOT] = '{default: NONE_SLOT};
   logic [31:0] m_delta [NSLOT] = '{default: DMASK};
   logic        m_linked [NSLOT] = '{default: 1'b0};
   logic [7:0]  m_head = NONE_SLOT;
   logic [7:0]  m_tail = NONE_SLOT;

   timer_op_type  pending_ops [$];
   list_view_type expected_views [$];
   int errors = 0;
   int num_sent = 0;
   int num_seen = 0;
   int send_idle = 0;
   int recv_idle = 0;
   int phase = 0;
   int hold_cycles = 0;
   logic hold_done = 1'b0;
   int quiet_cycles = 0;

   function automatic code_type list_insert(int s, logic [31:0] ticks);
      logic [31:0] rem;
      int t;
      int p;
      if (m_linked[s]) return ST_LINKED;
      rem = (ticks > DMAX) ? DMAX : ticks;
      m_linked[s] = 1'b1;
      if (m_head == NONE_SLOT) begin
         m_delta[s] = rem;
         m_head = 8'(s); m_tail = 8'(s);
         m_prev[s] = NONE_SLOT; m_next[s] = NONE_SLOT;
         return ST_OK;
      end
      t = m_head;
      for (int k = 0; k < NSLOT && t < NSLOT; k++) begin
         if (rem <= m_delta[t]) begin
            p = m_prev[t];
            m_prev[s] = 8'(p); m_next[s] = 8'(t); m_prev[t] = 8'(s);
            m_delta[t] = m_delta[t] - rem;
            m_delta[s] = rem;
            if (p < NSLOT) m_next[p] = 8'(s);
            else m_head = 8'(s);
            return ST_OK;
         end
         rem = rem - m_delta[t];
         t = m_next[t];
      end
      m_delta[s] = rem;
      if (m_tail < NSLOT) m_next[m_tail] = 8'(s);
      m_prev[s] = m_tail; m_next[s] = NONE_SLOT;
      m_tail = 8'(s);
      return ST_OK;
   endfunction

   function automatic code_type list_remove(int s, logic expired);
      int n;
      int p;
      logic [32:0] sum;
      if (!m_linked[s]) return ST_UNLINKED;
      n = m_next[s]; p = m_prev[s];
      if (p < NSLOT) m_next[p] = 8'(n);
      else m_head = 8'(n);
      if (n < NSLOT) m_prev[n] = 8'(p);
      else m_tail = 8'(p);
      if (!expired && n < NSLOT) begin
         sum = {1'b0, m_delta[n]} + {1'b0, m_delta[s]};
         m_delta[n] = (sum > {1'b0, DMAX}) ? DMAX : sum[31:0];
      end
      m_prev[s] = NONE_SLOT; m_next[s] = NONE_SLOT;
      m_delta[s] = DMASK; m_linked[s] = 1'b0;
      return ST_OK;
   endfunction

   function automatic list_view_type list_apply(timer_op_type op);
      list_view_type v;
      int s;
      v = '0;
      v.status = ST_OK;
      s = op.slot;
      case (op.func)
         FUNC_INSERT: if (s < NSLOT) v.status = list_insert(s, op.ticks);
         FUNC_REMOVE: if (s < NSLOT) v.status = list_remove(s, op.expired);
         FUNC_CLEAR: begin
            for (int i = 0; i < NSLOT; i++)
               if (m_linked[i]) begin
                  m_next[i] = NONE_SLOT; m_linked[i] = 1'b0;
               end
            m_head = NONE_SLOT; m_tail = NONE_SLOT;
         end
         default: begin
            if (s < NSLOT) begin
               v.nxt = m_next[s]; v.prv = m_prev[s]; v.delta = m_delta[s];
            end else begin
               v.nxt = NONE_SLOT; v.prv = NONE_SLOT; v.delta = DMASK;
            end
         end
      endcase
      v.head = m_head;
      v.tail = m_tail;
      v.empty = (m_head == NONE_SLOT);
      return v;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on result %0d: %s got %h want %h", num_seen, what, got, want);
      errors++;
   endtask

   task automatic push_op(func_type f, int s, logic [31:0] t, int e);
      timer_op_type op;
      op.func = f; op.slot = 8'(s); op.ticks = t; op.expired = 1'(e);
      pending_ops.push_back(op);
   endtask

   function automatic logic [31:0] rand_ticks();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 3);
         1: return DMASK - $urandom_range(0, 2);
         2: return $urandom;
         default: return $urandom_range(0, 200);
      endcase
   endfunction

   function automatic int rand_slot();
      if ($urandom_range(0, 19) == 0) return $urandom_range(NSLOT, 255);
      return $urandom_range(0, NSLOT - 1);
   endfunction

   task automatic fill_random(int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 45) push_op(FUNC_INSERT, rand_slot(), rand_ticks(), $urandom);
         else if (r < 70) push_op(FUNC_REMOVE, rand_slot(), $urandom, $urandom);
         else if (r < 73) push_op(FUNC_CLEAR, rand_slot(), $urandom, $urandom);
         else push_op(FUNC_READ, rand_slot(), $urandom, $urandom);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_views.push_back(list_apply(pending_ops.pop_front()));
            num_sent++;
         end
         if ((!req_chan.valid || req_chan.ready) && pending_ops.size() > 0
             && ($urandom_range(0, 99) >= send_idle)) begin
            req_chan.valid       <= 1'b1;
            req_chan.func        <= pending_ops[0].func;
            req_chan.timer_slot  <= pending_ops[0].slot;
            req_chan.start_ticks <= pending_ops[0].ticks;
            req_chan.expired     <= pending_ops[0].expired;
         end else if (req_chan.valid && req_chan.ready) begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      list_view_type w;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_views.size() == 0) begin
               report_mismatch("unexpected result", 0, 0);
            end else begin
               w = expected_views.pop_front();
               if (rsp_chan.head_slot !== w.head)
                  report_mismatch("head", 32'(rsp_chan.head_slot), 32'(w.head));
               if (rsp_chan.tail_slot !== w.tail)
                  report_mismatch("tail", 32'(rsp_chan.tail_slot), 32'(w.tail));
               if (rsp_chan.list_empty !== w.empty)
                  report_mismatch("empty", 32'(rsp_chan.list_empty), 32'(w.empty));
               if (rsp_chan.slot_next !== w.nxt)
                  report_mismatch("next", 32'(rsp_chan.slot_next), 32'(w.nxt));
               if (rsp_chan.slot_prev !== w.prv)
                  report_mismatch("prev", 32'(rsp_chan.slot_prev), 32'(w.prv));
               if (rsp_chan.slot_delta !== w.delta)
                  report_mismatch("delta", rsp_chan.slot_delta, w.delta);
               if (rsp_chan.status !== w.status)
                  report_mismatch("status", 32'(rsp_chan.status), 32'(w.status));
            end
            num_seen++;
         end
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_chan.ready <= 1'b0;
         end else if (phase == 3 && !hold_done) begin
            hold_cycles <= 300;
            hold_done <= 1'b1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
             || hold_cycles > 0)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WD_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WD_LIMIT);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic drain();
      while (pending_ops.size() > 0 || expected_views.size() > 0 || req_chan.valid)
         @(posedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed
      push_op(FUNC_READ, 0, 0, 0);
      push_op(FUNC_READ, 255, DMASK, 1);
      push_op(FUNC_INSERT, 3, 100, 0);
      push_op(FUNC_INSERT, 3, 5, 1);
      push_op(FUNC_INSERT, 5, 40, 0);
      push_op(FUNC_INSERT, 7, 100, 0);
      push_op(FUNC_INSERT, 0, 0, 0);
      push_op(FUNC_INSERT, NSLOT - 1, DMASK, 0);
      push_op(FUNC_INSERT, 9, DMAX, 0);
      push_op(FUNC_INSERT, 200, 7, 0);
      push_op(FUNC_READ, 3, 0, 0);
      push_op(FUNC_READ, 7, 0, 0);
      push_op(FUNC_REMOVE, 9, 0, 0);
      push_op(FUNC_REMOVE, 5, 0, 1);
      push_op(FUNC_REMOVE, 5, 0, 0);
      push_op(FUNC_REMOVE, 254, 0, 0);
      push_op(FUNC_REMOVE, 0, 0, 0);
      push_op(FUNC_READ, 0, 0, 0);
      push_op(FUNC_CLEAR, 0, 0, 0);
      push_op(FUNC_READ, 3, 0, 0);
      push_op(FUNC_READ, NSLOT - 1, 0, 0);
      push_op(FUNC_INSERT, 3, 1, 0);
      push_op(FUNC_REMOVE, 3, 0, 0);
      drain();

      phase = 1;
      send_idle = 26; recv_idle = 83;
      fill_random(400);
      drain();
      phase = 2;
      send_idle = 83; recv_idle = 26;
      fill_random(400);
      drain();
      phase = 3;
      send_idle = 0; recv_idle = 0;
      fill_random(400);
      drain();
      repeat (40) @(posedge clock);

      $display("run covered %0d requests and %0d results: insert, remove, clear, read",
               num_sent, num_seen);
      $display("with ties, saturation, out-of-range slots, refusals and back-pressure");
      if (errors == 0 && expected_views.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

[sim.f]
design/dtl_pkg.sv
design/dtl_req_if.sv
design/dtl_rsp_if.sv
design/dtl_ram.sv
design/dtl_datapath.sv
design/dtl_ctrl.sv
design/delta_timer_list_unit.sv
design/dtl_checker.sv
dv/tb.sv
